### hdl/tkc_pkg.sv
`default_nettype none

package tkc_pkg;

	localparam int MAX_RES = 4;

	// lexer modes
	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_SLASH = 3'd1;
	localparam logic [2:0] M_BLOCK = 3'd2;
	localparam logic [2:0] M_BSTAR = 3'd3;
	localparam logic [2:0] M_LINE  = 3'd4;
	localparam logic [2:0] M_WORD  = 3'd5;
	localparam logic [2:0] M_STR   = 3'd6;
	localparam logic [2:0] M_ESC   = 3'd7;

	// token kinds
	localparam logic [1:0] K_WORD = 2'd0;
	localparam logic [1:0] K_STR  = 2'd1;
	localparam logic [1:0] K_ONE  = 2'd2;

	// event codes
	localparam logic EV_CHAR = 1'b0;
	localparam logic EV_END  = 1'b1;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;

	typedef struct packed {
		logic        event_res;
		logic [7:0]  token_char;
		logic [1:0]  token_kind;
		logic [15:0] token_length;
	} tkc_res_t;

	typedef struct packed {
		tkc_res_t [MAX_RES-1:0] res;
		logic [2:0]             cnt;
	} tkc_bundle_t;

	function automatic tkc_res_t mk_char(input logic [7:0] ch, input logic [1:0] kind);
		tkc_res_t r;
		r.event_res    = EV_CHAR;
		r.token_char   = ch;
		r.token_kind   = kind;
		r.token_length = '0;
		return r;
	endfunction

	function automatic tkc_res_t mk_end(input logic [1:0] kind, input logic [15:0] len);
		tkc_res_t r;
		r.event_res    = EV_END;
		r.token_char   = '0;
		r.token_kind   = kind;
		r.token_length = len;
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
	endfunction

endpackage

`default_nettype wire

### hdl/tkc_lexer.sv
`default_nettype none

module tkc_lexer import tkc_pkg::*; #(
	parameter logic [15:0] LEN_CAP = 16'hFFFF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [255:0] single_set,
	input  wire logic [7:0]   byte_s1,
	input  wire logic         load,
	output tkc_bundle_t       bundle
);

	logic [2:0]  mode_q;
	logic [15:0] len_q;
	logic [2:0]  mode_d;
	logic [15:0] len_d;

	always_comb begin
		logic [2:0]             m;
		logic [15:0]            l;
		logic [2:0]             n;
		tkc_res_t [MAX_RES-1:0] res;
		logic                   go;
		logic                   b_single;
		logic [7:0]             c;

		m        = mode_q;
		l        = len_q;
		n        = '0;
		res      = '0;
		go       = 1'b1;
		b_single = (byte_s1 != CH_NUL) && single_set[byte_s1];
		c        = byte_s1;

		// held slash resolves first; unless it opens a comment, the byte then runs through idle or word
		if (m == M_SLASH) begin
			if (byte_s1 == CH_STAR) begin
				m  = M_BLOCK;
				go = 1'b0;
			end else if (byte_s1 == CH_SLASH) begin
				m  = M_LINE;
				go = 1'b0;
			end else if (single_set[CH_SLASH]) begin
				res[0] = mk_char(CH_SLASH, K_ONE);
				res[1] = mk_end(K_ONE, 16'd1);
				n      = 3'd2;
				m      = M_IDLE;
			end else begin
				res[0] = mk_char(CH_SLASH, K_WORD);
				n      = 3'd1;
				l      = 16'd1;
				m      = M_WORD;
			end
		end

		if (go) begin
			case (m)
				M_IDLE: begin
					l = '0;
					if (byte_s1 == CH_NUL) begin
						m = M_IDLE;
					end else if (byte_s1 == CH_SLASH) begin
						m = M_SLASH;
					end else if (is_space(byte_s1)) begin
						m = M_IDLE;
					end else if (b_single) begin
						res[n[1:0]] = mk_char(byte_s1, K_ONE);
						n = n + 3'd1;
						res[n[1:0]] = mk_end(K_ONE, 16'd1);
						n = n + 3'd1;
						m = M_IDLE;
					end else if (byte_s1 == CH_QUOTE) begin
						m = M_STR;
					end else begin
						m = M_WORD;
						res[n[1:0]] = mk_char(byte_s1, K_WORD);
						n = n + 3'd1;
						if (l < LEN_CAP) l = l + 16'd1;
					end
				end
				M_WORD: begin
					if (byte_s1 == CH_NUL || is_space(byte_s1)) begin
						res[n[1:0]] = mk_end(K_WORD, l);
						n = n + 3'd1;
						l = '0;
						m = M_IDLE;
					end else if (b_single) begin
						res[n[1:0]] = mk_end(K_WORD, l);
						n = n + 3'd1;
						res[n[1:0]] = mk_char(byte_s1, K_ONE);
						n = n + 3'd1;
						res[n[1:0]] = mk_end(K_ONE, 16'd1);
						n = n + 3'd1;
						l = '0;
						m = M_IDLE;
					end else begin
						res[n[1:0]] = mk_char(byte_s1, K_WORD);
						n = n + 3'd1;
						if (l < LEN_CAP) l = l + 16'd1;
					end
				end
				M_BLOCK: begin
					if (byte_s1 == CH_NUL) m = M_IDLE;
					else if (byte_s1 == CH_STAR) m = M_BSTAR;
				end
				M_BSTAR: begin
					if (byte_s1 == CH_NUL || byte_s1 == CH_SLASH) m = M_IDLE;
					else if (byte_s1 != CH_STAR) m = M_BLOCK;
				end
				M_LINE: begin
					if (byte_s1 == CH_NUL || byte_s1 == CH_LF) m = M_IDLE;
				end
				M_STR: begin
					if (byte_s1 == CH_NUL || byte_s1 == CH_QUOTE) begin
						if (l != '0) begin
							res[n[1:0]] = mk_end(K_STR, l);
							n = n + 3'd1;
						end
						l = '0;
						m = M_IDLE;
					end else if (byte_s1 == CH_BSLASH) begin
						m = M_ESC;
					end else begin
						res[n[1:0]] = mk_char(byte_s1, K_STR);
						n = n + 3'd1;
						if (l < LEN_CAP) l = l + 16'd1;
					end
				end
				M_ESC: begin
					if (byte_s1 == CH_NUL) begin
						if (l != '0) begin
							res[n[1:0]] = mk_end(K_STR, l);
							n = n + 3'd1;
						end
						l = '0;
						m = M_IDLE;
					end else begin
						if (byte_s1 == CH_N) c = CH_LF;
						else if (byte_s1 == CH_T) c = CH_TAB;
						res[n[1:0]] = mk_char(c, K_STR);
						n = n + 3'd1;
						if (l < LEN_CAP) l = l + 16'd1;
						m = M_STR;
					end
				end
				default: begin
				end
			endcase
		end

		mode_d     = m;
		len_d      = l;
		bundle.res = res;
		bundle.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q  <= '0;
		end else if (load) begin
			mode_q <= mode_d;
			len_q  <= len_d;
		end
	end

`ifndef SYNTHESIS
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n) len_q <= LEN_CAP)
		else $error("token length above cap");
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDLE || mode_q == M_SLASH || mode_q == M_BLOCK ||
		 mode_q == M_BSTAR || mode_q == M_LINE) |-> len_q == '0)
		else $error("length left over outside a token");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> bundle.cnt <= 3'd4)
		else $error("too many results for one byte");
`endif

endmodule

`default_nettype wire

### hdl/tkc_out.sv
`default_nettype none

module tkc_out import tkc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_s1,
	input  wire tkc_bundle_t bundle,
	output logic             load,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // token_char, token_length
	output logic [2:0]       m_tuser,  // event_res, token_kind
	output logic             m_tlast
);

	tkc_res_t [MAX_RES-1:0] slot_q;
	logic [2:0]             rem_q;
	logic [1:0]             rd_q;
	tkc_res_t               cur;
	logic                   free;

	assign free = (rem_q == 3'd0) || (rem_q == 3'd1 && m_tready);
	assign load = valid_s1 && free;

	always_ff @(posedge clk) begin
		if (load) slot_q <= bundle.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			rem_q <= bundle.cnt;
			rd_q  <= '0;
		end else if (m_tvalid && m_tready) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	assign cur      = slot_q[rd_q];
	assign m_tvalid = rem_q != 3'd0;
	assign m_tdata  = {cur.token_length, cur.token_char};
	assign m_tuser  = {cur.token_kind, cur.event_res};
	assign m_tlast  = rem_q == 3'd1;

`ifndef SYNTHESIS
	a_rem_max: assert property (@(posedge clk) disable iff (!arst_n) rem_q <= 3'd4)
		else $error("result count overflow");
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(4'(rd_q) + 4'(rem_q)) <= 4'd4)
		else $error("read pointer past bundle");
	a_keep_going: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("bundle dropped before its last result");
`endif

endmodule

`default_nettype wire

### hdl/text_tokenizer_with_comments.sv
// Text tokenizer with block/line comments and quoted strings.
// Input channel s_*: one text byte per item in s_tdata; byte zero ends the
// text and flushes any open token.
// Output channel m_*: one item per event. m_tuser[0] is 0 for a token
// character (m_tdata[7:0]) and 1 for end of token (m_tdata[23:8] length);
// m_tuser[2:1] is the token kind. m_tlast marks the final item caused by
// one input byte; a byte may cause zero to four items.
// cfg_*: writes the four 64-bit one-character token masks; write only
// while no byte is in flight.
// An accepted byte waits in the input register; its items are then loaded
// into the result register. Throughput: one byte per cycle while each byte
// gives at most one item and the receiver is ready; a byte with more items
// holds the single result register, draining one item per ready cycle.
// The input register keeps taking a byte while results wait; when the
// receiver stalls, results hold and s_tready drops once the input register
// is also full. Reset returns the lexer to idle between tokens, clears the
// masks and empties both registers.
`default_nettype none

module text_tokenizer_with_comments import tkc_pkg::*; #(
	parameter longint unsigned LENGTH_MAX = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // text_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // token_char, token_length
	output logic [2:0]       m_tuser,  // event_res, token_kind
	output logic             m_tlast
);

	localparam logic [15:0] LEN_CAP =
		(LENGTH_MAX < 64'd65535) ? 16'(LENGTH_MAX) : 16'hFFFF;

	logic [3:0][63:0] set_q;
	logic [7:0]       byte_s1;
	logic             valid_s1;
	logic             load;
	tkc_bundle_t      bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q <= '0;
		end else if (cfg_wr_en) begin
			set_q[cfg_addr] <= cfg_data;
		end
	end

	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	tkc_lexer #(.LEN_CAP(LEN_CAP)) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.single_set (set_q),
		.byte_s1    (byte_s1),
		.load       (load),
		.bundle     (bundle)
	);

	tkc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.bundle   (bundle),
		.load     (load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
